### sv/nfsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash store package
// Shared sizes, field widths, codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package nfsm_pkg;

  // Storage sizes
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MAX_RUN   = 256;

  localparam int unsigned MEM_AW = $clog2(MEM_BYTES);
  localparam int unsigned IDX_W  = $clog2(MEM_BYTES + 1);
  localparam int unsigned RUN_CW = $clog2(MAX_RUN + 1);
  localparam int unsigned RUN_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  // Field widths
  localparam int unsigned OPC_W     = 2;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SUM_W     = LEN_W + 1;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_PROGRAM = 2'd0;
  localparam logic [OPC_W-1:0] OP_ERASE   = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR    = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] PARTITION_RST = 17'd65536;
  localparam logic [CFG_W-1:0] SECTOR_RST    = 17'd4096;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_RANGE      = 3'd1,
    ST_SETS_BIT   = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_e;

  // Which base address the memory walk adds its index to
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_RUN,
    BASE_ITEM
  } base_sel_e;

  typedef struct packed {
    logic      capture;
    logic      idx_clr;
    logic      idx_inc;
    base_sel_e base_sel;
    logic      fl_rd;
    logic      fl_wr;
    logic      fl_wr_ones;
    logic      buf_rd;
    logic      div_start;
    logic      div_len;
    logic      run_clr;
    logic      res_load;
    status_e   res_status;
    logic      res_data;
  } cmd_t;

  typedef struct packed {
    logic clr_end;
    logic run_end;
    logic er_end;
    logic run_ovf;
    logic run_range_bad;
    logic er_range_bad;
    logic rd_range_bad;
    logic sec_zero;
    logic div_busy;
    logic rem_nz;
    logic mismatch;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### sv/nfsm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash store channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface nfsm_in_if;
  logic                            valid;
  logic                            ready;
  logic [nfsm_pkg::OPC_W-1:0]      opcode;
  logic [nfsm_pkg::ADDR_W-1:0]     address;
  logic [nfsm_pkg::DATA_W-1:0]     data_byte;
  logic [nfsm_pkg::LEN_W-1:0]      erase_length;
  logic                            last;

  modport source (output valid, opcode, address, data_byte, erase_length, last,
                  input ready);
  modport sink (input valid, opcode, address, data_byte, erase_length, last,
                output ready);
endinterface

interface nfsm_out_if;
  logic                            valid;
  logic                            ready;
  logic [nfsm_pkg::STAT_W-1:0]     status;
  logic [nfsm_pkg::DATA_W-1:0]     read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface
`default_nettype wire

### sv/nfsm_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash store remainder unit
// Restoring division, one quotient bit per cycle; keeps only the remainder.
// ----------------------------------------------------------------------------
module nfsm_rem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [nfsm_pkg::LEN_W-1:0]    dividend_i,
  input  wire logic [nfsm_pkg::CFG_W-1:0]    divisor_i,
  output logic                               busy_o,
  output logic                               rem_nz_o
);

  localparam int unsigned CNT_W = $clog2(nfsm_pkg::LEN_W + 1);

  logic                         busy_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [nfsm_pkg::LEN_W-1:0]   dvd_q;
  logic [nfsm_pkg::CFG_W-1:0]   rem_q;
  logic [nfsm_pkg::CFG_W:0]     trial;
  logic [nfsm_pkg::CFG_W:0]     diff;

  assign trial = {rem_q, dvd_q[nfsm_pkg::LEN_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(nfsm_pkg::LEN_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // With a nonzero divisor the remainder stays below it, so it fits the divisor width.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[nfsm_pkg::LEN_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_q <= diff[nfsm_pkg::CFG_W-1:0];
      end else begin
        rem_q <= trial[nfsm_pkg::CFG_W-1:0];
      end
    end
  end

  assign busy_o   = busy_q;
  assign rem_nz_o = |rem_q;

endmodule
`default_nettype wire

### sv/nfsm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash store datapath
// Flash and run memories, configuration, run state, walk index and result.
// ----------------------------------------------------------------------------
module nfsm_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire nfsm_pkg::cmd_t                    cmd_i,
  output nfsm_pkg::sts_t                         sts_o,
  input  wire logic [nfsm_pkg::OPC_W-1:0]        opcode_i,
  input  wire logic [nfsm_pkg::ADDR_W-1:0]       address_i,
  input  wire logic [nfsm_pkg::DATA_W-1:0]       data_byte_i,
  input  wire logic [nfsm_pkg::LEN_W-1:0]        erase_length_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [nfsm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [nfsm_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [nfsm_pkg::STAT_W-1:0]            out_status_o,
  output logic [nfsm_pkg::DATA_W-1:0]            out_read_data_o
);

  logic [nfsm_pkg::CFG_W-1:0]   partition_q;
  logic [nfsm_pkg::CFG_W-1:0]   sector_q;
  logic [nfsm_pkg::ADDR_W-1:0]  addr_q;
  logic [nfsm_pkg::LEN_W-1:0]   elen_q;
  logic [nfsm_pkg::RUN_CW-1:0]  run_count_q;
  logic [nfsm_pkg::ADDR_W-1:0]  run_start_q;
  logic                         run_ovf_q;
  logic [nfsm_pkg::IDX_W-1:0]   idx_q;
  logic                         out_valid_q;
  logic [nfsm_pkg::STAT_W-1:0]  out_status_q;
  logic [nfsm_pkg::DATA_W-1:0]  out_data_q;

  logic [nfsm_pkg::DATA_W-1:0]  fl_mem [nfsm_pkg::MEM_BYTES];
  logic [nfsm_pkg::DATA_W-1:0]  buf_mem [nfsm_pkg::MAX_RUN];
  logic [nfsm_pkg::DATA_W-1:0]  fl_rdata_q;
  logic [nfsm_pkg::DATA_W-1:0]  buf_rdata_q;

  logic                         prog_beat;
  logic [nfsm_pkg::ADDR_W-1:0]  base;
  logic [nfsm_pkg::MEM_AW-1:0]  fl_addr;
  logic [nfsm_pkg::DATA_W-1:0]  fl_wdata;
  logic [nfsm_pkg::CFG_W-1:0]   usable;
  logic [nfsm_pkg::LEN_W-1:0]   dividend;
  logic                         div_busy;
  logic                         rem_nz;

  assign prog_beat = cmd_i.capture && (opcode_i == nfsm_pkg::OP_PROGRAM);

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partition_q <= nfsm_pkg::PARTITION_RST;
      sector_q    <= nfsm_pkg::SECTOR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == nfsm_pkg::CFG_PARTITION) begin
        partition_q <= cfg_data_i;
      end
      if (cfg_idx_i == nfsm_pkg::CFG_SECTOR) begin
        sector_q <= cfg_data_i;
      end
    end
  end

  // Captured request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= address_i;
      elen_q <= erase_length_i;
    end
  end

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= '0;
      run_start_q <= '0;
      run_ovf_q   <= 1'b0;
    end else if (cmd_i.run_clr) begin
      run_count_q <= '0;
      run_start_q <= '0;
      run_ovf_q   <= 1'b0;
    end else if (prog_beat) begin
      if ((run_count_q == '0) && !run_ovf_q) begin
        run_start_q <= address_i;
      end
      if (run_count_q < nfsm_pkg::RUN_CW'(nfsm_pkg::MAX_RUN)) begin
        run_count_q <= run_count_q + 1'b1;
      end else begin
        run_ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prog_beat && (run_count_q < nfsm_pkg::RUN_CW'(nfsm_pkg::MAX_RUN))) begin
      buf_mem[run_count_q[nfsm_pkg::RUN_AW-1:0]] <= data_byte_i;
    end
    if (cmd_i.buf_rd) begin
      buf_rdata_q <= buf_mem[idx_q[nfsm_pkg::RUN_AW-1:0]];
    end
  end

  // Walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.capture || cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Flash array
  always_comb begin
    case (cmd_i.base_sel)
      nfsm_pkg::BASE_RUN:  base = run_start_q;
      nfsm_pkg::BASE_ITEM: base = addr_q;
      default:             base = '0;
    endcase
  end

  assign fl_addr  = nfsm_pkg::MEM_AW'(base) + idx_q[nfsm_pkg::MEM_AW-1:0];
  assign fl_wdata = cmd_i.fl_wr_ones ? nfsm_pkg::ERASED_BYTE : buf_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fl_wr) begin
      fl_mem[fl_addr] <= fl_wdata;
    end
    if (cmd_i.fl_rd) begin
      fl_rdata_q <= fl_mem[fl_addr];
    end
  end

  // Alignment checks
  assign dividend = cmd_i.div_len ? elen_q : nfsm_pkg::LEN_W'(addr_q);

  nfsm_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (sector_q),
    .busy_o     (div_busy),
    .rem_nz_o   (rem_nz)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_data_q   <= cmd_i.res_data ? fl_rdata_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_read_data_o = out_data_q;

  // Status towards the controller
  assign usable = (partition_q > nfsm_pkg::CFG_W'(nfsm_pkg::MEM_BYTES)) ?
                  nfsm_pkg::CFG_W'(nfsm_pkg::MEM_BYTES) : partition_q;

  always_comb begin
    sts_o.clr_end       = idx_q == nfsm_pkg::IDX_W'(nfsm_pkg::MEM_BYTES - 1);
    sts_o.run_end       = idx_q == nfsm_pkg::IDX_W'(run_count_q);
    sts_o.er_end        = idx_q == nfsm_pkg::IDX_W'(elen_q);
    sts_o.run_ovf       = run_ovf_q;
    sts_o.run_range_bad = (nfsm_pkg::SUM_W'(run_start_q) + nfsm_pkg::SUM_W'(run_count_q))
                          > nfsm_pkg::SUM_W'(usable);
    sts_o.er_range_bad  = (nfsm_pkg::SUM_W'(addr_q) + nfsm_pkg::SUM_W'(elen_q))
                          > nfsm_pkg::SUM_W'(usable);
    sts_o.rd_range_bad  = nfsm_pkg::CFG_W'(addr_q) >= usable;
    sts_o.sec_zero      = sector_q == '0;
    sts_o.div_busy      = div_busy;
    sts_o.rem_nz        = rem_nz;
    sts_o.mismatch      = (buf_rdata_q | fl_rdata_q) != fl_rdata_q;
    sts_o.out_busy      = out_valid_q && !out_ready_i;
  end

endmodule
`default_nettype wire

### sv/nfsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash store controller
// Sequences the clearing pass, run verify and commit, erase and read.
// ----------------------------------------------------------------------------
module nfsm_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [nfsm_pkg::OPC_W-1:0]   in_opcode_i,
  input  wire logic                         in_last_i,
  output logic                              in_ready_o,
  input  wire nfsm_pkg::sts_t               sts_i,
  output nfsm_pkg::cmd_t                    cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PROG_CHK,
    S_VER_RD,
    S_VER_CMP,
    S_COM_RD,
    S_COM_WR,
    S_DIV_START,
    S_DIV_START_WAIT,
    S_DIV_LEN_WAIT,
    S_ER_WR,
    S_RD_RD,
    S_RD_DONE,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  nfsm_pkg::status_e  res_code_q, res_code_d;
  logic               res_data_q, res_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      res_code_q <= nfsm_pkg::ST_OK;
      res_data_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      res_code_q <= res_code_d;
      res_data_q <= res_data_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    res_code_d = res_code_q;
    res_data_d = res_data_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res_status = res_code_q;
    cmd_o.res_data   = res_data_q;

    case (state_q)
      S_CLEAR: begin
        cmd_o.base_sel   = nfsm_pkg::BASE_ZERO;
        cmd_o.fl_wr      = 1'b1;
        cmd_o.fl_wr_ones = 1'b1;
        cmd_o.idx_inc    = 1'b1;
        if (sts_i.clr_end) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        res_data_d    = 1'b0;
        if (in_valid_i) begin
          if (in_opcode_i == nfsm_pkg::OP_PROGRAM) begin
            if (in_last_i) begin
              state_d = S_PROG_CHK;
            end
          end else if (in_opcode_i == nfsm_pkg::OP_ERASE) begin
            state_d = S_DIV_START;
          end else if (in_opcode_i == nfsm_pkg::OP_READ) begin
            state_d = S_RD_RD;
          end
        end
      end

      S_PROG_CHK: begin
        if (sts_i.run_ovf) begin
          res_code_d    = nfsm_pkg::ST_TOO_LONG;
          cmd_o.run_clr = 1'b1;
          state_d       = S_RESP;
        end else if (sts_i.run_range_bad) begin
          res_code_d    = nfsm_pkg::ST_RANGE;
          cmd_o.run_clr = 1'b1;
          state_d       = S_RESP;
        end else begin
          state_d = S_VER_RD;
        end
      end

      S_VER_RD: begin
        cmd_o.base_sel = nfsm_pkg::BASE_RUN;
        if (sts_i.run_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_COM_RD;
        end else begin
          cmd_o.fl_rd  = 1'b1;
          cmd_o.buf_rd = 1'b1;
          state_d      = S_VER_CMP;
        end
      end

      S_VER_CMP: begin
        if (sts_i.mismatch) begin
          res_code_d    = nfsm_pkg::ST_SETS_BIT;
          cmd_o.run_clr = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_VER_RD;
        end
      end

      S_COM_RD: begin
        if (sts_i.run_end) begin
          res_code_d    = nfsm_pkg::ST_OK;
          cmd_o.run_clr = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.buf_rd = 1'b1;
          state_d      = S_COM_WR;
        end
      end

      S_COM_WR: begin
        cmd_o.base_sel = nfsm_pkg::BASE_RUN;
        cmd_o.fl_wr    = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_COM_RD;
      end

      S_DIV_START: begin
        if (sts_i.sec_zero) begin
          res_code_d = nfsm_pkg::ST_MISALIGNED;
          state_d    = S_RESP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_START_WAIT;
        end
      end

      S_DIV_START_WAIT: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rem_nz) begin
            res_code_d = nfsm_pkg::ST_MISALIGNED;
            state_d    = S_RESP;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_len   = 1'b1;
            state_d         = S_DIV_LEN_WAIT;
          end
        end
      end

      S_DIV_LEN_WAIT: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rem_nz) begin
            res_code_d = nfsm_pkg::ST_MISALIGNED;
            state_d    = S_RESP;
          end else if (sts_i.er_range_bad) begin
            res_code_d = nfsm_pkg::ST_RANGE;
            state_d    = S_RESP;
          end else begin
            state_d = S_ER_WR;
          end
        end
      end

      S_ER_WR: begin
        if (sts_i.er_end) begin
          res_code_d = nfsm_pkg::ST_OK;
          state_d    = S_RESP;
        end else begin
          cmd_o.base_sel   = nfsm_pkg::BASE_ITEM;
          cmd_o.fl_wr      = 1'b1;
          cmd_o.fl_wr_ones = 1'b1;
          cmd_o.idx_inc    = 1'b1;
        end
      end

      S_RD_RD: begin
        if (sts_i.rd_range_bad) begin
          res_code_d = nfsm_pkg::ST_RANGE;
          state_d    = S_RESP;
        end else begin
          cmd_o.base_sel = nfsm_pkg::BASE_ITEM;
          cmd_o.fl_rd    = 1'b1;
          state_d        = S_RD_DONE;
        end
      end

      S_RD_DONE: begin
        res_code_d = nfsm_pkg::ST_OK;
        res_data_d = 1'b1;
        state_d    = S_RESP;
      end

      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/nor_flash_store_model_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash store core
// Byte-wide NOR flash model with buffered program runs, sector erase and read.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 65536-byte flash array to 0xFF, one byte a
// cycle, and the request channel stays not ready until the sweep is done;
// configuration writes are taken throughout. Program beats without the last
// flag are buffered in the run memory and the block is ready again in the next
// cycle, so a run streams in at one beat per cycle. On the last beat the run
// is checked for length and range, then verified against the array byte by
// byte (one memory read, one compare), then committed byte by byte (run
// memory read, array write), as each memory has a single port. An erase first
// checks the start and then the length against the sector size in a shared
// bit-serial remainder unit, then checks the range and writes a byte a cycle.
// A read checks its address for range and then reads one byte of the array. A
// program beat without the last flag and an unknown opcode give no result
// beat; every other request gives exactly one. Results sit in an output
// register, so a new request is accepted while the previous result still
// waits to be taken.
// ----------------------------------------------------------------------------
module nor_flash_store_model_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  nfsm_in_if.sink                               in_i,
  nfsm_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [nfsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [nfsm_pkg::CFG_W-1:0]       cfg_data_i
);

  // Command and status bundles between the sequencer and the datapath.
  nfsm_pkg::cmd_t  cmd;
  nfsm_pkg::sts_t  sts;
  logic            in_ready;

  assign in_i.ready = in_ready;

  // The controller sees only the valid, opcode and last signals of a request to
  // decide where a beat goes; the payload itself is captured by the datapath.
  nfsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds both memories, the run state, the configuration
  // registers and the result register that drives the output channel.
  nfsm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (in_i.opcode),
    .address_i       (in_i.address),
    .data_byte_i     (in_i.data_byte),
    .erase_length_i  (in_i.erase_length),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_status_o    (out_o.status),
    .out_read_data_o (out_o.read_data)
  );

endmodule
`default_nettype wire
